// ===== hdl/pfa_pkg.sv =====
// Package for the page frame allocator: request codes, sequencer state codes
// and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

   // Request field widths, fixed by the interface.
   localparam int PID_IN_W     = 16;
   localparam int PAGE_COUNT_W = 7;
   localparam int FIRST_W      = 6;
   localparam int FREED_W      = 7;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Sequencer states.
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ALLOC = 3'd2;
   localparam logic [2:0] ST_FREE  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

endpackage

// ===== hdl/page_frame_allocator_unit.sv =====
// Page frame allocator top level: sequencer around the free-frame stack RAM
// and the owner table RAM. Depends on pfa_pkg and pfa_ram.
`timescale 1ns / 1ps

// Usage:
// A request (req_mode, req_process_id, req_page_count) is taken when req_valid
// and req_ready are both high; exactly one response (rsp_ok, rsp_first_frame,
// rsp_frames_freed) follows on the rsp_ channel for each request.
// An allocate pops req_page_count frames off the free stack, one stack read per
// cycle, and writes the owner table as each frame returns from the RAM.
// A refused or zero-page allocate goes straight to the response.
// A free scans the whole owner table, one entry per cycle, pushing each frame
// the process owns back onto the stack. The single read port of each RAM sets
// these rates. One request is worked on at a time; req_ready is high only while
// the sequencer is idle. After reset the block loads the stack with frames 0 to
// NUM_FRAMES-1 and clears the owner table, with req_ready low.
// The response sits in an output register, so the next request is accepted
// while a response waits; if the receiver still stalls when the next response
// is ready, the sequencer holds it and stops taking requests.
module page_frame_allocator_unit #(
   parameter int NUM_FRAMES = 64,
   parameter int PID_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [pfa_pkg::PID_IN_W-1:0]      req_process_id,
   input  logic [pfa_pkg::PAGE_COUNT_W-1:0]  req_page_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [pfa_pkg::FIRST_W-1:0]       rsp_first_frame,
   output logic [pfa_pkg::FREED_W-1:0]       rsp_frames_freed
);

   localparam int FB = $clog2(NUM_FRAMES);
   localparam int CB = $clog2(NUM_FRAMES + 1);
   localparam int OW = PID_BITS + 1;
   localparam int PCW = pfa_pkg::PAGE_COUNT_W;

   logic [2:0]          state_ff, state_in;
   logic [FB-1:0]       init_cnt_ff, init_cnt_in;
   logic [CB-1:0]       free_count_ff, free_count_in;
   logic [PID_BITS-1:0] pid_ff, pid_in;
   logic [PCW-1:0]      cnt_ff, cnt_in;
   logic [PCW-1:0]      issued_ff, issued_in;
   logic [PCW-1:0]      returned_ff, returned_in;
   logic [FB-1:0]       rd_addr_ff, rd_addr_in;
   logic [CB-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                pend_ff, pend_in;
   logic [FB-1:0]       pend_addr_ff, pend_addr_in;
   logic                res_ok_ff, res_ok_in;
   logic [5:0]          res_first_ff, res_first_in;
   logic [CB-1:0]       res_freed_ff, res_freed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [5:0]          rsp_first_ff, rsp_first_in;
   logic [6:0]          rsp_freed_ff, rsp_freed_in;

   logic          stk_we, stk_re;
   logic [FB-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
   logic          own_we, own_re;
   logic [FB-1:0] own_waddr, own_raddr;
   logic [OW-1:0] own_wdata, own_rdata;

   logic [31:0]   pid_ext;
   logic [31:0]   frame_ext;
   logic [31:0]   freed_ext;
   logic [CB-1:0] top_idx;
   logic          own_hit;

   pfa_ram #(.WIDTH(FB), .DEPTH(NUM_FRAMES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Each owner entry is {owned flag, owner id}.
   pfa_ram #(.WIDTH(OW), .DEPTH(NUM_FRAMES)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_en   (own_re),
      .rd_addr (own_raddr),
      .rd_data (own_rdata)
   );

   assign pid_ext   = 32'(req_process_id);
   assign frame_ext = 32'(stk_rdata);
   assign freed_ext = 32'(res_freed_ff);
   assign top_idx   = free_count_ff - CB'(1);
   assign own_hit   = own_rdata[PID_BITS] && (own_rdata[PID_BITS-1:0] == pid_ff);

   assign req_ready        = (state_ff == pfa_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_first_frame  = rsp_first_ff;
   assign rsp_frames_freed = rsp_freed_ff;

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      free_count_in = free_count_ff;
      pid_in        = pid_ff;
      cnt_in        = cnt_ff;
      issued_in     = issued_ff;
      returned_in   = returned_ff;
      rd_addr_in    = rd_addr_ff;
      scan_cnt_in   = scan_cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_ok_in     = res_ok_ff;
      res_first_in  = res_first_ff;
      res_freed_in  = res_freed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_freed_in  = rsp_freed_ff;

      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = rd_addr_ff;
      own_we    = 1'b0;
      own_waddr = '0;
      own_wdata = '0;
      own_re    = 1'b0;
      own_raddr = scan_cnt_ff[FB-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pfa_pkg::ST_INIT: begin
            stk_we      = 1'b1;
            stk_waddr   = init_cnt_ff;
            stk_wdata   = init_cnt_ff;
            own_we      = 1'b1;
            own_waddr   = init_cnt_ff;
            own_wdata   = '0;
            init_cnt_in = init_cnt_ff + FB'(1);
            if (init_cnt_ff == FB'(NUM_FRAMES - 1)) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         pfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               pid_in       = pid_ext[PID_BITS-1:0];
               cnt_in       = req_page_count;
               issued_in    = '0;
               returned_in  = '0;
               rd_addr_in   = top_idx[FB-1:0];
               scan_cnt_in  = '0;
               res_ok_in    = 1'b1;
               res_first_in = '0;
               res_freed_in = '0;
               if (req_mode == pfa_pkg::MODE_FREE) begin
                  state_in = pfa_pkg::ST_FREE;
               end else if (32'(req_page_count) > 32'(free_count_ff)) begin
                  res_ok_in = 1'b0;
                  state_in  = pfa_pkg::ST_DONE;
               end else if (req_page_count == '0) begin
                  state_in = pfa_pkg::ST_DONE;
               end else begin
                  state_in = pfa_pkg::ST_ALLOC;
               end
            end
         end
         pfa_pkg::ST_ALLOC: begin
            // Stack reads walk down from the top, one per cycle; the stack is
            // not written during an allocate, so reads never need forwarding.
            if (issued_ff != cnt_ff) begin
               stk_re     = 1'b1;
               rd_addr_in = rd_addr_ff - FB'(1);
               issued_in  = issued_ff + PCW'(1);
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               own_we      = 1'b1;
               own_waddr   = stk_rdata;
               own_wdata   = {1'b1, pid_ff};
               returned_in = returned_ff + PCW'(1);
               if (returned_ff == '0) begin
                  res_first_in = frame_ext[5:0];
               end
               if (returned_ff + PCW'(1) == cnt_ff) begin
                  free_count_in = free_count_ff - CB'(cnt_ff);
                  state_in      = pfa_pkg::ST_DONE;
               end
            end
         end
         pfa_pkg::ST_FREE: begin
            // Owner reads run one entry ahead of the write-back; the write
            // always targets the previous entry, so the two never collide.
            if (scan_cnt_ff != CB'(NUM_FRAMES)) begin
               own_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = scan_cnt_ff[FB-1:0];
               scan_cnt_in  = scan_cnt_ff + CB'(1);
            end
            if (pend_ff) begin
               if (own_hit) begin
                  own_we       = 1'b1;
                  own_waddr    = pend_addr_ff;
                  own_wdata    = {1'b0, own_rdata[PID_BITS-1:0]};
                  res_freed_in = res_freed_ff + CB'(1);
                  if (free_count_ff < CB'(NUM_FRAMES)) begin
                     stk_we        = 1'b1;
                     stk_waddr     = free_count_ff[FB-1:0];
                     stk_wdata     = pend_addr_ff;
                     free_count_in = free_count_ff + CB'(1);
                  end
               end
               if (pend_addr_ff == FB'(NUM_FRAMES - 1)) begin
                  state_in = pfa_pkg::ST_DONE;
               end
            end
         end
         pfa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_first_in = res_first_ff;
               rsp_freed_in = freed_ext[6:0];
               state_in     = pfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfa_pkg::ST_INIT;
         init_cnt_ff   <= '0;
         free_count_ff <= CB'(NUM_FRAMES);
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         free_count_ff <= free_count_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff       <= pid_in;
      cnt_ff       <= cnt_in;
      issued_ff    <= issued_in;
      returned_ff  <= returned_in;
      rd_addr_ff   <= rd_addr_in;
      scan_cnt_ff  <= scan_cnt_in;
      pend_addr_ff <= pend_addr_in;
      res_ok_ff    <= res_ok_in;
      res_first_ff <= res_first_in;
      res_freed_ff <= res_freed_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_first_ff <= rsp_first_in;
      rsp_freed_ff <= rsp_freed_in;
   end

endmodule

// ===== hdl/pfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/tb_page_frame_allocator_unit.sv =====
// Self-checking testbench for page_frame_allocator_unit: directed and random
// allocate and free requests checked against a predictor of the free stack and
// owner table. Depends on pfa_pkg and the RTL of the block.
`timescale 1ns / 1ps

typedef struct packed {
   logic       ok;
   logic [5:0] first_frame;
   logic [6:0] frames_freed;
} frame_response_type;

class frame_owner_model;
   localparam int FRAMES = 64;

   logic [5:0]         free_stack [FRAMES];
   int unsigned        free_count;
   logic [15:0]        owner_id [FRAMES];
   bit                 owned [FRAMES];
   frame_response_type expected_responses [$];
   int unsigned        mismatches;

   function new();
      for (int i = 0; i < FRAMES; i++) begin
         free_stack[i] = i[5:0];
         owner_id[i]   = '0;
         owned[i]      = 1'b0;
      end
      free_count  = FRAMES;
      mismatches  = 0;
   endfunction

   // Applies one accepted request to the model and queues its response.
   function void take_request(logic mode, logic [15:0] pid, logic [6:0] count);
      frame_response_type rsp;
      int unsigned        top;
      logic [5:0]         frame;
      rsp = '{ok: 1'b1, first_frame: '0, frames_freed: '0};
      if (mode == pfa_pkg::MODE_ALLOC) begin
         if (count > free_count) begin
            rsp.ok = 1'b0;
         end else begin
            for (int i = 0; i < count; i++) begin
               top   = free_count - 1;
               frame = free_stack[top];
               if (i == 0)
                  rsp.first_frame = frame;
               free_count      = top;
               owner_id[frame] = pid;
               owned[frame]    = 1'b1;
            end
         end
      end else begin
         for (int f = 0; f < FRAMES; f++) begin
            if (owned[f] && owner_id[f] == pid) begin
               owned[f] = 1'b0;
               if (free_count < FRAMES) begin
                  free_stack[free_count] = f[5:0];
                  free_count++;
               end
               rsp.frames_freed++;
            end
         end
      end
      expected_responses = {expected_responses, rsp};
   endfunction

   function void check_response(logic ok, logic [5:0] first_frame, logic [6:0] freed);
      frame_response_type exp;
      if (expected_responses.size() == 0) begin
         $display("%0t: response with no request outstanding: ok=%0d first=%0d freed=%0d",
                  $time, ok, first_frame, freed);
         mismatches++;
         return;
      end
      exp = expected_responses.pop_front();
      if (ok !== exp.ok) begin
         $display("%0t: ok mismatch: expected %0d, actual %0d", $time, exp.ok, ok);
         mismatches++;
      end
      if (first_frame !== exp.first_frame) begin
         $display("%0t: first_frame mismatch: expected %0d, actual %0d",
                  $time, exp.first_frame, first_frame);
         mismatches++;
      end
      if (freed !== exp.frames_freed) begin
         $display("%0t: frames_freed mismatch: expected %0d, actual %0d",
                  $time, exp.frames_freed, freed);
         mismatches++;
      end
   endfunction

   function int unsigned outstanding();
      return expected_responses.size();
   endfunction
endclass

module tb_page_frame_allocator_unit;

   localparam int NUM_FRAMES    = 64;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASE  = 338;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [15:0] req_process_id;
   logic [6:0]  req_page_count;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_ok;
   logic [5:0]  rsp_first_frame;
   logic [6:0]  rsp_frames_freed;

   frame_owner_model owners;
   int unsigned      cycle_count = 0;
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   logic [15:0]      pid_pool [6];

   page_frame_allocator_unit #(
      .NUM_FRAMES(NUM_FRAMES),
      .PID_BITS  (16)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_process_id  (req_process_id),
      .req_page_count  (req_page_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_first_frame (rsp_first_frame),
      .rsp_frames_freed(rsp_frames_freed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_page_frame_allocator_unit: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         owners.check_response(rsp_ok, rsp_first_frame, rsp_frames_freed);
   end

   // Holds the request until accepted; valid is only lowered across an idle gap.
   task automatic send_request(logic mode, logic [15:0] pid, logic [6:0] count);
      int unsigned gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_process_id <= pid;
      req_page_count <= count;
      do @(posedge clock); while (!req_ready);
      owners.take_request(mode, pid, count);
   endtask

   // Mostly allocations and frees from a small set of owners so that the stack
   // drains and refills; a few requests carry arbitrary ids and counts.
   task automatic send_random_request();
      int unsigned pick;
      int unsigned size_pick;
      logic [6:0]  count;
      logic [15:0] pid;
      pick = $urandom_range(99);
      pid  = pid_pool[3'($urandom_range(5))];
      if (pick < 8) begin
         send_request(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                      7'($urandom_range(127)));
      end else if (pick < 35) begin
         send_request(pfa_pkg::MODE_FREE, pid, 7'($urandom_range(127)));
      end else begin
         size_pick = $urandom_range(99);
         if (size_pick < 70)
            count = 7'($urandom_range(8));
         else if (size_pick < 90)
            count = 7'($urandom_range(24));
         else if (size_pick < 97)
            count = 7'($urandom_range(64, 25));
         else
            count = 7'($urandom_range(127, 65));
         send_request(pfa_pkg::MODE_ALLOC, pid, count);
      end
   endtask

   initial begin
      owners         = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= pfa_pkg::MODE_ALLOC;
      req_process_id <= '0;
      req_page_count <= '0;
      for (int i = 0; i < 6; i++)
         pid_pool[i] = 16'($urandom_range(16'hFFFF));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero-page allocate, full drain, refusals, free of nothing.
      send_request(pfa_pkg::MODE_ALLOC, 16'h0000, 7'd0);
      send_request(pfa_pkg::MODE_FREE,  16'h0000, 7'd0);
      send_request(pfa_pkg::MODE_ALLOC, 16'hFFFF, 7'd64);
      send_request(pfa_pkg::MODE_ALLOC, 16'h1234, 7'd1);
      send_request(pfa_pkg::MODE_ALLOC, 16'h1234, 7'd127);
      send_request(pfa_pkg::MODE_FREE,  16'hFFFF, 7'd127);
      send_request(pfa_pkg::MODE_ALLOC, 16'h0000, 7'd65);
      send_request(pfa_pkg::MODE_ALLOC, 16'h0000, 7'd1);
      send_request(pfa_pkg::MODE_ALLOC, 16'hA5A5, 7'd63);
      send_request(pfa_pkg::MODE_ALLOC, 16'h5A5A, 7'd0);
      send_request(pfa_pkg::MODE_FREE,  16'h5A5A, 7'd0);
      send_request(pfa_pkg::MODE_FREE,  16'h0000, 7'd0);
      send_request(pfa_pkg::MODE_ALLOC, 16'h5A5A, 7'd2);
      send_request(pfa_pkg::MODE_FREE,  16'hA5A5, 7'd0);
      send_request(pfa_pkg::MODE_FREE,  16'h5A5A, 7'd0);
      send_request(pfa_pkg::MODE_ALLOC, 16'h8001, 7'd64);
      send_request(pfa_pkg::MODE_FREE,  16'h8001, 7'h55);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int n = 0; n < RANDOM_PHASE; n++)
            send_random_request();
      end
      req_valid <= 1'b0;

      while (owners.outstanding() != 0)
         @(posedge clock);
      repeat (NUM_FRAMES + 8) @(posedge clock);

      if (owners.mismatches == 0 && owners.outstanding() == 0)
         $display("tb_page_frame_allocator_unit: PASS");
      else
         $display("tb_page_frame_allocator_unit: FAIL");
      $finish;
   end

endmodule

// ===== page_frame_allocator_unit.f =====
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/page_frame_allocator_unit.sv
bench/tb_page_frame_allocator_unit.sv
